// ----- sv/gha_pkg.sv -----
// Shared types and constants for the generational handle allocator.
package gha_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int GEN_W      = 16;
    localparam int NAME_W     = 32;
    localparam int FUNC_W     = 4;

    localparam logic [FUNC_W-1:0] FN_CREATE     = 4'd0;
    localparam logic [FUNC_W-1:0] FN_DESTROY    = 4'd1;
    localparam logic [FUNC_W-1:0] FN_ALIVE      = 4'd2;
    localparam logic [FUNC_W-1:0] FN_ACTIVE_Q   = 4'd3;
    localparam logic [FUNC_W-1:0] FN_SET_ACTIVE = 4'd4;
    localparam logic [FUNC_W-1:0] FN_SET_NAME   = 4'd5;
    localparam logic [FUNC_W-1:0] FN_GET_NAME   = 4'd6;
    localparam logic [FUNC_W-1:0] FN_FIND       = 4'd7;
    localparam logic [FUNC_W-1:0] FN_COUNT      = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_FIND,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic              alive;
        logic              active;
        logic [GEN_W-1:0]  gen;
        logic [NAME_W-1:0] name;
    } slot_entry_t;

    typedef struct packed {
        logic peek;
        logic take;
        logic push;
    } stack_cmd_t;

endpackage

// ----- sv/gha_free_stack.sv -----
// LIFO of freed slot numbers with its depth counter and registered top read.
module gha_free_stack import gha_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  stack_cmd_t        cmd,
    input  logic [SLOT_W-1:0] push_slot,
    output logic [CNT_W-1:0]  depth,
    output logic [SLOT_W-1:0] top_slot
);

    logic [SLOT_W-1:0] stack_mem [SLOT_COUNT];
    logic [SLOT_W-1:0] top_reg;
    logic [CNT_W-1:0]  depth_reg;
    logic [CNT_W-1:0]  depth_next;
    logic [SLOT_W-1:0] top_addr;

    assign top_addr = SLOT_W'(depth_reg - CNT_W'(1));

    always_comb begin
        depth_next = depth_reg;
        priority if (cmd.push) begin
            depth_next = depth_reg + CNT_W'(1);
        end else if (cmd.take) begin
            depth_next = depth_reg - CNT_W'(1);
        end else begin
            depth_next = depth_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
    end

    // Read the top entry ahead of the pop that commits it
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stack_mem[depth_reg[SLOT_W-1:0]] <= push_slot;
        end
        if (cmd.peek) begin
            top_reg <= stack_mem[top_addr];
        end
    end

    assign depth    = depth_reg;
    assign top_slot = top_reg;

endmodule

// ----- sv/generational_handle_allocator_top.sv -----
// Top level of the generational handle allocator: slot table, sequencer, result register.
//
// Usage: present a request word on the s_ channel (func, handle, name, active flag)
// with s_valid; it is taken when s_valid and s_ready are both high. Exactly one
// result word comes back on the m_ channel per request, in request order.
// One request is in flight at a time; s_ready is high only while the sequencer
// idles, whether or not an earlier result still waits in the output register.
// Steps per request when the receiver keeps up; the result word is registered
// in the last step, after which s_ready rises again:
//   - alive, active?, set active, set name, get name, destroy, count, and create
//     from the high-water mark or on a full table: slot read, then check and
//     write back;
//   - create that reuses a freed slot: free stack read, slot read, then
//     write back;
//   - find: a walk over the slots, at most up to the high-water mark, then the
//     result; the slot table has one read port and gives one slot per cycle.
// Reset clears the sequencer, the free stack depth, the high-water mark, the
// live count and the result valid flag; the memories need no clearing since
// every slot below the high-water mark has been written by a create.
// When the receiver stalls, hold the result and its fields until m_ready;
// the sequencer waits in its last step and takes no new word meanwhile.
module generational_handle_allocator_top import gha_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [3:0]        s_func,
    input  logic [7:0]        s_handle_slot,
    input  logic [15:0]       s_handle_gen,
    input  logic [31:0]       s_name_value,
    input  logic              s_active_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_ok,
    output logic [7:0]        m_out_slot,
    output logic [15:0]       m_out_gen,
    output logic [31:0]       m_out_name,
    output logic [8:0]        m_live_total
);

    // Sequencer state and the latched request
    state_t            state_reg, state_next;
    logic [FUNC_W-1:0] req_func_reg;
    logic [SLOT_W-1:0] req_slot_reg;
    logic [GEN_W-1:0]  req_gen_reg;
    logic [NAME_W-1:0] req_name_reg;
    logic              req_act_reg;

    // Slot being worked on (handle, popped slot or scan position)
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic              found_reg, found_next;

    // Table bookkeeping
    logic [CNT_W-1:0]  hw_reg, hw_next;
    logic [CNT_W-1:0]  live_reg, live_next;

    // Slot table: one write port, one registered read port
    slot_entry_t       slot_mem [SLOT_COUNT];
    slot_entry_t       rd_entry_reg;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_entry_t       wr_data;

    // Free stack
    stack_cmd_t        stack_cmd;
    logic [SLOT_W-1:0] push_slot;
    logic [CNT_W-1:0]  stack_depth;
    logic [SLOT_W-1:0] stack_top;

    // Result register
    logic              m_valid_reg, m_valid_next;
    logic              m_ok_reg, m_ok_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;
    logic [GEN_W-1:0]  m_gen_reg, m_gen_next;
    logic [NAME_W-1:0] m_name_reg, m_name_next;
    logic [CNT_W-1:0]  m_live_reg, m_live_next;

    logic              handle_valid;
    logic              name_hit;
    logic              out_free;

    gha_free_stack u_free_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (stack_cmd),
        .push_slot (push_slot),
        .depth     (stack_depth),
        .top_slot  (stack_top)
    );

    // A handle is good when its slot is below the high-water mark, alive and
    // carries the stored generation
    assign handle_valid = (CNT_W'(req_slot_reg) < hw_reg) && rd_entry_reg.alive
                          && (rd_entry_reg.gen == req_gen_reg);
    assign name_hit     = rd_entry_reg.alive && rd_entry_reg.active
                          && (rd_entry_reg.name == req_name_reg);
    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cur_slot_next = cur_slot_reg;
        found_next    = found_reg;
        hw_next       = hw_reg;
        live_next     = live_reg;
        rd_en         = 1'b0;
        rd_addr       = s_handle_slot;
        wr_en         = 1'b0;
        wr_addr       = cur_slot_reg;
        wr_data       = rd_entry_reg;
        stack_cmd     = '0;
        push_slot     = req_slot_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_ok_next     = m_ok_reg;
        m_slot_next   = m_slot_reg;
        m_gen_next    = m_gen_reg;
        m_name_next   = m_name_reg;
        m_live_next   = m_live_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cur_slot_next = s_handle_slot;
                    found_next    = 1'b0;
                    priority if (s_func == FN_CREATE && stack_depth != '0) begin
                        // Fetch the most recently freed slot first
                        stack_cmd.peek = 1'b1;
                        state_next     = ST_POP;
                    end else if (s_func == FN_FIND) begin
                        if (hw_reg != '0) begin
                            rd_en         = 1'b1;
                            rd_addr       = '0;
                            cur_slot_next = '0;
                            state_next    = ST_FIND;
                        end else begin
                            state_next = ST_EXEC;
                        end
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = s_handle_slot;
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_POP: begin
                rd_en         = 1'b1;
                rd_addr       = stack_top;
                cur_slot_next = stack_top;
                state_next    = ST_EXEC;
            end

            ST_FIND: begin
                // Check the slot read last cycle; stop on a hit or at the mark
                priority if (name_hit) begin
                    found_next = 1'b1;
                    state_next = ST_EXEC;
                end else if (CNT_W'(cur_slot_reg) + CNT_W'(1) == hw_reg) begin
                    state_next = ST_EXEC;
                end else begin
                    rd_en         = 1'b1;
                    rd_addr       = cur_slot_reg + SLOT_W'(1);
                    cur_slot_next = cur_slot_reg + SLOT_W'(1);
                end
            end

            ST_EXEC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = 1'b0;
                    m_slot_next  = '0;
                    m_gen_next   = '0;
                    m_name_next  = '0;
                    state_next   = ST_IDLE;
                    unique case (req_func_reg)
                        FN_CREATE: begin
                            priority if (stack_depth != '0) begin
                                stack_cmd.take = 1'b1;
                                wr_en          = 1'b1;
                                wr_addr        = cur_slot_reg;
                                wr_data        = '{alive: 1'b1, active: req_act_reg,
                                                   gen: rd_entry_reg.gen,
                                                   name: req_name_reg};
                                live_next      = live_reg + CNT_W'(1);
                                m_ok_next      = 1'b1;
                                m_slot_next    = cur_slot_reg;
                                m_gen_next     = rd_entry_reg.gen;
                            end else if (hw_reg < CNT_W'(SLOT_COUNT)) begin
                                wr_en       = 1'b1;
                                wr_addr     = hw_reg[SLOT_W-1:0];
                                wr_data     = '{alive: 1'b1, active: req_act_reg,
                                                gen: '0, name: req_name_reg};
                                hw_next     = hw_reg + CNT_W'(1);
                                live_next   = live_reg + CNT_W'(1);
                                m_ok_next   = 1'b1;
                                m_slot_next = hw_reg[SLOT_W-1:0];
                            end else begin
                                m_ok_next = 1'b0;
                            end
                        end
                        FN_DESTROY: begin
                            if (handle_valid) begin
                                wr_en   = 1'b1;
                                wr_addr = req_slot_reg;
                                wr_data = '{alive: 1'b0, active: 1'b0,
                                            gen: rd_entry_reg.gen + GEN_W'(1),
                                            name: '0};
                                if (stack_depth < CNT_W'(SLOT_COUNT)) begin
                                    stack_cmd.push = 1'b1;
                                end
                                if (live_reg != '0) begin
                                    live_next = live_reg - CNT_W'(1);
                                end
                                m_ok_next = 1'b1;
                            end
                        end
                        FN_ALIVE: begin
                            m_ok_next = handle_valid;
                        end
                        FN_ACTIVE_Q: begin
                            m_ok_next = handle_valid && rd_entry_reg.active;
                        end
                        FN_SET_ACTIVE: begin
                            if (handle_valid) begin
                                wr_en          = 1'b1;
                                wr_addr        = req_slot_reg;
                                wr_data.active = req_act_reg;
                            end
                            m_ok_next = handle_valid;
                        end
                        FN_SET_NAME: begin
                            if (handle_valid) begin
                                wr_en        = 1'b1;
                                wr_addr      = req_slot_reg;
                                wr_data.name = req_name_reg;
                            end
                            m_ok_next = handle_valid;
                        end
                        FN_GET_NAME: begin
                            m_ok_next = handle_valid;
                            if (handle_valid) begin
                                m_name_next = rd_entry_reg.name;
                            end
                        end
                        FN_FIND: begin
                            m_ok_next = found_reg;
                            if (found_reg) begin
                                m_slot_next = cur_slot_reg;
                                m_gen_next  = rd_entry_reg.gen;
                            end
                        end
                        FN_COUNT: begin
                            m_ok_next = 1'b1;
                        end
                        default: begin
                            m_ok_next = 1'b0;
                        end
                    endcase
                    m_live_next = live_next;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hw_reg      <= '0;
            live_reg    <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hw_reg      <= hw_next;
            live_reg    <= live_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: latch the request word on acceptance
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_func_reg <= s_func;
            req_slot_reg <= s_handle_slot;
            req_gen_reg  <= s_handle_gen;
            req_name_reg <= s_name_value;
            req_act_reg  <= s_active_value;
        end
        cur_slot_reg <= cur_slot_next;
        m_ok_reg     <= m_ok_next;
        m_slot_reg   <= m_slot_next;
        m_gen_reg    <= m_gen_next;
        m_name_reg   <= m_name_next;
        m_live_reg   <= m_live_next;
    end

    // Slot table memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_entry_reg <= slot_mem[rd_addr];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_out_slot   = m_slot_reg;
    assign m_out_gen    = m_gen_reg;
    assign m_out_name   = m_name_reg;
    assign m_live_total = m_live_reg;

endmodule

// ----- sv/gha_checker.sv -----
// Port-level checks for the generational handle allocator, bound to the top level.
module gha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_ok,
    input logic [7:0]  m_out_slot,
    input logic [15:0] m_out_gen,
    input logic [31:0] m_out_name,
    input logic [8:0]  m_live_total
);

    // Hold a stalled result word steady
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ok) && $stable(m_out_slot)
            && $stable(m_out_gen) && $stable(m_out_name) && $stable(m_live_total))
        else $error("stalled result word changed");

    // One request in flight: drop ready right after an acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in flight");

    // A failed or negative answer carries no handle and no name
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_out_slot == 8'd0 && m_out_gen == 16'd0
            && m_out_name == 32'd0)
        else $error("failed result carries payload");

    // Live count never exceeds the table size
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_live_total <= 9'd256)
        else $error("live count beyond table size");

endmodule

bind generational_handle_allocator_top gha_checker u_gha_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for the generational handle allocator: driver, monitor, predictor.
`timescale 1ns / 1ps

module testbench;
    import gha_pkg::*;

    // Sizes of the run.
    localparam int RANDOM_WORDS = 240;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 20;
    localparam int LONG_HOLD    = 400;
    localparam int PRINT_CAP    = 100;

    // Two copies of the slot table: one follows the words as they are planned,
    // so that the generator knows which handles are live; the other follows
    // the words as the block accepts them and yields the expected results.
    localparam int PLAN_SIDE  = 0;
    localparam int CHECK_SIDE = 1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
        logic [GEN_W-1:0]  gen;
        logic [NAME_W-1:0] name;
        logic              act;
    } request_t;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [GEN_W-1:0]  gen;
        logic [NAME_W-1:0] name;
        logic [CNT_W-1:0]  live;
    } response_t;

    logic              aclk;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [3:0]        s_func         = '0;
    logic [7:0]        s_handle_slot  = '0;
    logic [15:0]       s_handle_gen   = '0;
    logic [31:0]       s_name_value   = '0;
    logic              s_active_value = 1'b0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic              m_ok;
    logic [7:0]        m_out_slot;
    logic [15:0]       m_out_gen;
    logic [31:0]       m_out_name;
    logic [8:0]        m_live_total;

    // Slot table copies, indexed by side.
    logic              slot_alive  [2][SLOT_COUNT];
    logic              slot_active [2][SLOT_COUNT];
    logic [GEN_W-1:0]  slot_gen    [2][SLOT_COUNT];
    logic [NAME_W-1:0] slot_name   [2][SLOT_COUNT];
    logic [SLOT_W-1:0] free_slots  [2][SLOT_COUNT];
    logic [CNT_W-1:0]  free_depth  [2];
    logic [CNT_W-1:0]  high_mark   [2];
    logic [CNT_W-1:0]  live_count  [2];

    request_t  pending_words[$];
    response_t expected_results[$];
    request_t  next_word;
    request_t  taken_word;
    response_t want;

    int        queued_total   = 0;
    int        accepted_total = 0;
    int        error_count    = 0;
    int        cycle_count    = 0;
    logic      word_taken     = 1'b0;

    // Flow control state. The stimulus process raises hold_request with a
    // nonblocking assignment so that the receiver sees it a step later.
    logic      hold_request   = 1'b0;
    logic      hold_done      = 1'b0;
    int        hold_left      = 0;
    int        burst_left     = 0;
    int        gap_left       = 0;
    int        stall_mode     = 0;
    int        stall_window   = 0;

    generational_handle_allocator_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_handle_slot  (s_handle_slot),
        .s_handle_gen   (s_handle_gen),
        .s_name_value   (s_name_value),
        .s_active_value (s_active_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ok           (m_ok),
        .m_out_slot     (m_out_slot),
        .m_out_gen      (m_out_gen),
        .m_out_name     (m_out_name),
        .m_live_total   (m_live_total)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_tables();
        for (int w = 0; w < 2; w++) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_alive[w][i]  = 1'b0;
                slot_active[w][i] = 1'b0;
                slot_gen[w][i]    = '0;
                slot_name[w][i]   = '0;
                free_slots[w][i]  = '0;
            end
            free_depth[w] = '0;
            high_mark[w]  = '0;
            live_count[w] = '0;
        end
    endfunction

    // Apply one request word to one copy of the table and return its result word.
    function automatic response_t allocator_step(input int w, input request_t rq);
        response_t         rs;
        logic              valid;
        logic              found;
        logic [SLOT_W-1:0] s;
        rs    = '0;
        found = 1'b0;
        s     = '0;
        // A handle counts only below the high-water mark, alive, and of the
        // slot's current generation.
        valid = (rq.slot < high_mark[w]) && slot_alive[w][rq.slot]
                && (slot_gen[w][rq.slot] == rq.gen);
        case (rq.func)
            FN_CREATE: begin
                // Reuse the most recently freed slot first, else grow the table.
                if (free_depth[w] != 0) begin
                    free_depth[w] = free_depth[w] - 1'b1;
                    s = free_slots[w][free_depth[w][SLOT_W-1:0]];
                    found = 1'b1;
                end else if (high_mark[w] < SLOT_COUNT) begin
                    s = high_mark[w][SLOT_W-1:0];
                    high_mark[w] = high_mark[w] + 1'b1;
                    slot_gen[w][s] = '0;
                    found = 1'b1;
                end
                if (found) begin
                    slot_alive[w][s]  = 1'b1;
                    slot_active[w][s] = rq.act;
                    slot_name[w][s]   = rq.name;
                    live_count[w]     = live_count[w] + 1'b1;
                    rs.ok   = 1'b1;
                    rs.slot = s;
                    rs.gen  = slot_gen[w][s];
                end
            end
            FN_DESTROY: begin
                if (valid) begin
                    slot_alive[w][rq.slot]  = 1'b0;
                    slot_active[w][rq.slot] = 1'b0;
                    slot_name[w][rq.slot]   = '0;
                    slot_gen[w][rq.slot]    = slot_gen[w][rq.slot] + 1'b1;
                    if (free_depth[w] < SLOT_COUNT) begin
                        free_slots[w][free_depth[w][SLOT_W-1:0]] = rq.slot;
                        free_depth[w] = free_depth[w] + 1'b1;
                    end
                    if (live_count[w] != 0)
                        live_count[w] = live_count[w] - 1'b1;
                    rs.ok = 1'b1;
                end
            end
            FN_ALIVE: begin
                rs.ok = valid;
            end
            FN_ACTIVE_Q: begin
                rs.ok = valid && slot_active[w][rq.slot];
            end
            FN_SET_ACTIVE: begin
                if (valid)
                    slot_active[w][rq.slot] = rq.act;
                rs.ok = valid;
            end
            FN_SET_NAME: begin
                if (valid)
                    slot_name[w][rq.slot] = rq.name;
                rs.ok = valid;
            end
            FN_GET_NAME: begin
                rs.ok = valid;
                if (valid)
                    rs.name = slot_name[w][rq.slot];
            end
            FN_FIND: begin
                // Lowest alive, active slot carrying the name wins.
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!found && i < high_mark[w] && slot_alive[w][i] && slot_active[w][i]
                            && slot_name[w][i] == rq.name) begin
                        found   = 1'b1;
                        rs.ok   = 1'b1;
                        rs.slot = SLOT_W'(i);
                        rs.gen  = slot_gen[w][i];
                    end
                end
            end
            FN_COUNT: begin
                rs.ok = 1'b1;
            end
            default: begin
            end
        endcase
        rs.live = live_count[w];
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_word(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot,
                             input logic [GEN_W-1:0] gen, input logic [NAME_W-1:0] name,
                             input logic act);
        request_t rq;
        rq = '{func: func, slot: slot, gen: gen, name: name, act: act};
        void'(allocator_step(PLAN_SIDE, rq));
        pending_words = {pending_words, rq};
        queued_total++;
    endtask

    // Pick a live slot of the planned table, starting at a random place.
    function automatic logic pick_live(output logic [SLOT_W-1:0] s);
        int   start;
        int   idx;
        logic hit;
        hit   = 1'b0;
        s     = '0;
        start = $urandom_range(0, SLOT_COUNT - 1);
        for (int k = 0; k < SLOT_COUNT; k++) begin
            idx = (start + k) % SLOT_COUNT;
            if (!hit && slot_alive[PLAN_SIDE][idx]) begin
                hit = 1'b1;
                s   = SLOT_W'(idx);
            end
        end
        return hit;
    endfunction

    // Names come mostly from a small pool so that finds and renames collide.
    function automatic logic [NAME_W-1:0] pick_name();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h0000_0001;
            4, 5:    return NAME_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        // Keep the log short when the block is badly broken; the count still rises.
        if (error_count <= PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Wait until every queued word has been taken and answered.
    task automatic wait_drain();
        @(negedge aclk);
        while (accepted_total != queued_total || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer words at the falling edge, in bursts with gaps between.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || word_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                next_word = pending_words.pop_front();
                s_func         <= next_word.func;
                s_handle_slot  <= next_word.slot;
                s_handle_gen   <= next_word.gen;
                s_name_value   <= next_word.name;
                s_active_value <= next_word.act;
                s_valid        <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, plus one long hold-off so that the
    // output register stays full and the block stops taking words.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            if (stall_window == 0) begin
                stall_mode   = $urandom_range(0, 3);
                stall_window = $urandom_range(8, 80);
            end
            stall_window--;
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= $urandom_range(0, 1);
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, check a result word against the oldest
    // expectation, then predict the result of any word taken at this edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        word_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_error("result word with nothing outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (m_ok !== want.ok)
                        report_error($sformatf("ok got %0d want %0d", m_ok, want.ok));
                    if (m_out_slot !== want.slot)
                        report_error($sformatf("out_slot got %0d want %0d",
                                               m_out_slot, want.slot));
                    if (m_out_gen !== want.gen)
                        report_error($sformatf("out_gen got %0d want %0d",
                                               m_out_gen, want.gen));
                    if (m_out_name !== want.name)
                        report_error($sformatf("out_name got %h want %h",
                                               m_out_name, want.name));
                    if (m_live_total !== want.live)
                        report_error($sformatf("live_total got %0d want %0d",
                                               m_live_total, want.live));
                end
            end
            if (s_valid && s_ready) begin
                taken_word = '{func: s_func, slot: s_handle_slot, gen: s_handle_gen,
                               name: s_name_value, act: s_active_value};
                expected_results = {expected_results,
                                    allocator_step(CHECK_SIDE, taken_word)};
                accepted_total++;
            end
        end
    end

    // Run watchdog: count cycles and give up at a generous limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [SLOT_W-1:0] hs;
        logic [GEN_W-1:0]  hg;
        logic              got;
        int                r;
        clear_tables();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words from an empty table.
        push_word(FN_COUNT, '0, '0, '0, 1'b0);
        push_word(FN_ALIVE, 8'd0, 16'd0, '0, 1'b0);            // slot not below high-water
        push_word(FN_CREATE, '1, '1, '1, 1'b1);                // slot 0, generation 0
        push_word(FN_ALIVE, 8'd0, 16'd0, '0, 1'b0);
        push_word(FN_ALIVE, 8'd0, 16'hFFFF, '0, 1'b0);         // wrong generation
        push_word(FN_ALIVE, 8'd255, 16'd0, '0, 1'b0);
        push_word(FN_ACTIVE_Q, 8'd0, 16'd0, '0, 1'b0);
        push_word(FN_SET_ACTIVE, 8'd0, 16'd0, '0, 1'b0);
        push_word(FN_ACTIVE_Q, 8'd0, 16'd0, '0, 1'b0);
        push_word(FN_FIND, '0, '0, '1, 1'b0);                  // inactive, so not found
        push_word(FN_SET_ACTIVE, 8'd0, 16'd0, '0, 1'b1);
        push_word(FN_FIND, '0, '0, '1, 1'b0);
        push_word(FN_SET_NAME, 8'd0, 16'd0, '0, 1'b0);
        push_word(FN_GET_NAME, 8'd0, 16'd0, '1, 1'b1);
        push_word(FN_CREATE, '0, '0, '0, 1'b0);                // slot 1
        push_word(FN_FIND, '0, '0, '0, 1'b0);
        push_word(FN_DESTROY, 8'd0, 16'd0, '0, 1'b0);
        push_word(FN_DESTROY, 8'd0, 16'd0, '0, 1'b0);          // stale handle
        push_word(FN_GET_NAME, 8'd0, 16'd0, '0, 1'b0);
        push_word(FN_SET_ACTIVE, 8'd0, 16'd0, '0, 1'b1);
        push_word(FN_SET_NAME, 8'd0, 16'd0, '1, 1'b0);
        push_word(FN_CREATE, '0, '0, '1, 1'b1);                // reuse slot 0, generation 1
        push_word(FN_GET_NAME, 8'd0, 16'd1, '0, 1'b0);
        push_word(4'd9, '1, '1, '1, 1'b1);                     // unused codes
        push_word(4'd15, '1, '1, '1, 1'b1);
        push_word(FN_FIND, '0, '0, 32'h1234_5678, 1'b0);       // no match
        push_word(FN_COUNT, '1, '1, '1, 1'b1);
        wait_drain();

        // Fill the table, then knock on it while full.
        for (int k = 0; k < SLOT_COUNT; k++)
            push_word(FN_CREATE, '0, '0, NAME_W'(32'h0000_1000 + k), (k % 5) != 0);
        push_word(FN_ALIVE, 8'd255, 16'd0, '0, 1'b0);
        push_word(FN_FIND, '0, '0, slot_name[PLAN_SIDE][255], 1'b0);
        push_word(FN_GET_NAME, 8'd255, 16'd0, '0, 1'b0);
        push_word(FN_COUNT, '0, '0, '0, 1'b0);
        for (int k = 0; k < 40; k++) begin
            got = pick_live(hs);
            push_word(FN_DESTROY, hs, slot_gen[PLAN_SIDE][hs], '0, 1'b0);
        end
        // Pop every freed slot back, and overrun into a full table again.
        for (int k = 0; k < 45; k++)
            push_word(FN_CREATE, '0, '0, pick_name(), 1'($urandom_range(0, 1)));
        push_word(FN_COUNT, '0, '0, '0, 1'b0);
        wait_drain();

        // Random words, mostly on handles known to be live. Start the long
        // receiver hold-off at once, while the queue is full.
        hold_request <= 1'b1;
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            r   = $urandom_range(0, 99);
            got = pick_live(hs);
            if (r < 12) begin
                // Noise: any code, any handle.
                push_word(FUNC_W'($urandom_range(0, 15)), SLOT_W'($urandom),
                          GEN_W'($urandom), $urandom, 1'($urandom_range(0, 1)));
            end else if (r < 30 || !got) begin
                push_word(FN_CREATE, SLOT_W'($urandom), GEN_W'($urandom), pick_name(),
                          1'($urandom_range(0, 1)));
            end else if (r < 42) begin
                push_word(FN_DESTROY, hs, slot_gen[PLAN_SIDE][hs], $urandom,
                          1'($urandom_range(0, 1)));
            end else if (r < 50) begin
                // Live slot, forged generation.
                hg = slot_gen[PLAN_SIDE][hs] ^ (GEN_W'(1) << $urandom_range(0, GEN_W - 1));
                push_word(FUNC_W'($urandom_range(FN_DESTROY, FN_GET_NAME)), hs, hg,
                          pick_name(), 1'($urandom_range(0, 1)));
            end else if (r < 60) begin
                push_word(FN_FIND, SLOT_W'($urandom), GEN_W'($urandom),
                          $urandom_range(0, 1) ? slot_name[PLAN_SIDE][hs] : pick_name(),
                          1'($urandom_range(0, 1)));
            end else if (r < 64) begin
                push_word(FN_COUNT, SLOT_W'($urandom), GEN_W'($urandom), $urandom,
                          1'($urandom_range(0, 1)));
            end else begin
                push_word(FUNC_W'($urandom_range(FN_ALIVE, FN_GET_NAME)), hs,
                          slot_gen[PLAN_SIDE][hs], pick_name(), 1'($urandom_range(0, 1)));
            end
        end
        wait_drain();

        // Let any stray result word show itself before the verdict.
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
